// ===== src/dds_env_pkg.sv =====
// Package for the DDS tone voice: widths, reset values, register indexes,
// and the note-increment and sine tables built at elaboration.
// No dependencies.
`default_nettype none

package dds_env_pkg;

  localparam int unsigned SINE_DEPTH = 256;
  localparam int unsigned SINE_AW    = $clog2(SINE_DEPTH);

  localparam int unsigned NOTE_COUNT  = 15;
  localparam int unsigned NOTE_AW     = $clog2(NOTE_COUNT);
  localparam int unsigned NOTES_PER_SCALE = 5;

  localparam logic [15:0] DAC_CHAN_B_CMD   = 16'hB000;
  localparam logic [15:0] DAC_MID          = 16'd2048;
  localparam logic [31:0] PHASE_RESET_STEP = 32'd34359738;
  localparam logic [16:0] AMP_RESET        = 17'd0;
  localparam logic [15:0] ATTACK_RESET     = 16'd131;
  localparam logic [15:0] DECAY_RESET      = 16'd131;
  localparam logic [15:0] FULL_RESET       = 16'd32768;

  // tick rate times 100, since the note table is in centihertz
  localparam logic [63:0] TICK_CENTIHZ = 64'd5000000;
  localparam logic [63:0] PI_Q30       = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30  = PI_Q30 / 64'd2;
  localparam logic [63:0] ANGLE_DIV    = 64'd1000 * 64'(SINE_DEPTH);

  // serial multiplier: digit width and digit count per product
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MPLIER_W   = 20;
  localparam int unsigned MUL_DIGITS = MPLIER_W / DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(MUL_DIGITS);

  typedef enum logic [1:0] {
    REG_ATTACK = 2'd0,
    REG_DECAY  = 2'd1,
    REG_FULL   = 2'd2
  } reg_idx_e;

  typedef logic signed [26:0] sine_rom_t [SINE_DEPTH];
  typedef logic [31:0]        note_rom_t [NOTE_COUNT];
  typedef logic [15:0]        centihz_t  [NOTE_COUNT];

  localparam centihz_t NOTE_CENTIHZ = '{
    16'd22000, 16'd24694, 16'd27718, 16'd32963, 16'd37000,
    16'd26163, 16'd29366, 16'd32963, 16'd39200, 16'd44000,
    16'd19600, 16'd22000, 16'd24694, 16'd29366, 16'd32963
  };

  function automatic note_rom_t build_note_rom();
    note_rom_t rom;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      rom[i] = 32'((64'(NOTE_CENTIHZ[i]) << 32) / TICK_CENTIHZ);
    end
    return rom;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    logic        neg;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x   = ((64'(i) * 64'd6283) << 30) / ANGLE_DIV;
      neg = 1'b0;
      if (x > PI_Q30) begin
        neg = 1'b1;
        x   = x - PI_Q30;
      end
      if (x > HALF_PI_Q30) begin
        x = (x < PI_Q30) ? (PI_Q30 - x) : 64'd0;
      end
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      // Taylor terms with divisors (2k)(2k+1), k = 1..6, signs alternating
      term = ((term * x2) >> 30) / 64'd6;
      sum  = (sum > term) ? (sum - term) : 64'd0;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = (sum > term) ? (sum - term) : 64'd0;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = (sum > term) ? (sum - term) : 64'd0;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      mag    = (64'd2047 * sum) >> 15;
      rom[i] = neg ? -27'(mag) : 27'(mag);
    end
    return rom;
  endfunction

  localparam note_rom_t NOTE_STEP_ROM = build_note_rom();
  localparam sine_rom_t SINE_ROM      = build_sine_rom();

endpackage

`default_nettype wire

// ===== src/dds_tone_with_envelope_core.sv =====
// DDS sine voice with linear attack/decay envelope, one request per sample tick.
// Uses dds_env_pkg for the note and sine tables and the reset constants.
`default_nettype none

// For a held key with a valid note, one shared 32 x 4-bit multiplier runs
// five digit steps to scale the note increment by the pitch multiplier, the
// phase advances and the sine entry is fetched, and five more digit steps
// form amplitude times sine. A released key with nonzero amplitude skips the
// first product; a request that produces no word is consumed in its accept
// cycle. The result sits in an output register, so the next request is taken
// while it waits. Attack, decay and full level are written through the plain
// write port and should change only while the voice is idle.
module dds_tone_with_envelope_core
  import dds_env_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,

  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        key_held_i,
  input  wire logic [2:0]  note_i,
  input  wire logic [1:0]  scale_i,
  input  wire logic [15:0] pitch_mult_i,

  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [15:0] dac_word_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_ADV  = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_MUL2 = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] attack_q, decay_q, full_q;
  logic [31:0] phase_q, phase_d;
  logic [31:0] step_q, step_d;
  logic [16:0] amp_q, amp_d;
  logic        held_q, held_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] dac_word_q, dac_word_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // serial multiplier datapath, no reset
  logic [31:0]         mcand_q, mcand_d;
  logic [MPLIER_W-1:0] mplier_q, mplier_d;
  logic [31:0]         acc_q, acc_d;
  logic [MPLIER_W-1:0] lo_q, lo_d;
  logic                neg_q, neg_d;

  logic                    note_ok;
  logic [NOTE_AW-1:0]      note_idx;
  logic [35:0]             mul_sum;
  logic                    mul_last;
  logic [31:0]             prod_step;
  logic [31:0]             step_use;
  logic signed [26:0]      sine_val;
  logic [26:0]             sine_mag;
  logic [12:0]             q_floor;
  logic                    q_round;
  logic [13:0]             q_mag;
  logic [15:0]             sample;
  logic [16:0]             attack_sum;
  logic [16:0]             amp_attack;
  logic [16:0]             amp_decay;

  assign note_ok  = key_held_i && (note_i <= 3'd4) && (scale_i <= 2'd2);
  assign note_idx = NOTE_AW'(scale_i) * NOTE_AW'(NOTES_PER_SCALE) + NOTE_AW'(note_i);

  assign mul_sum  = {4'd0, acc_q} + (36'(mcand_q) * 36'(mplier_q[DIGIT_W-1:0]));
  assign mul_last = (cnt_q == CNT_W'(MUL_DIGITS - 1));

  // (base * mult) >> 15, low 32 bits, from the finished product
  assign prod_step = {acc_q[26:0], lo_q[MPLIER_W-1 -: 5]};
  assign step_use  = held_q ? prod_step : step_q;

  assign sine_val = SINE_ROM[phase_q[31 -: SINE_AW]];
  assign sine_mag = sine_val[26] ? 27'(-sine_val) : 27'(sine_val);

  // floor for positive products, ceiling of the magnitude for negative ones
  assign q_floor = acc_q[22:10];
  assign q_round = neg_q && ({acc_q[9:0], lo_q} != '0);
  assign q_mag   = {1'b0, q_floor} + 14'(q_round);
  assign sample  = neg_q ? (DAC_MID - 16'(q_mag)) : (DAC_MID + 16'(q_mag));

  assign attack_sum = amp_q + 17'(attack_q);
  assign amp_attack = (amp_q < 17'(full_q))
                      ? ((attack_sum > 17'(full_q)) ? 17'(full_q) : attack_sum)
                      : amp_q;
  assign amp_decay  = (amp_q > 17'(decay_q)) ? (amp_q - 17'(decay_q)) : 17'd0;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign dac_word_o  = dac_word_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    step_d      = step_q;
    amp_d       = amp_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    dac_word_d  = dac_word_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    acc_d       = acc_q;
    lo_d        = lo_q;
    neg_d       = neg_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (note_ok) begin
            held_d   = 1'b1;
            mcand_d  = NOTE_STEP_ROM[note_idx];
            mplier_d = MPLIER_W'(pitch_mult_i);
            acc_d    = '0;
            cnt_d    = '0;
            state_d  = ST_MUL1;
          end else if (amp_q != 17'd0) begin
            // decay comes before the word on a released key
            held_d  = 1'b0;
            amp_d   = amp_decay;
            state_d = ST_ADV;
          end
        end
      end
      ST_MUL1, ST_MUL2: begin
        acc_d    = mul_sum[35:4];
        lo_d     = {mul_sum[3:0], lo_q[MPLIER_W-1:DIGIT_W]};
        mplier_d = mplier_q >> DIGIT_W;
        cnt_d    = cnt_q + CNT_W'(1);
        if (mul_last) begin
          state_d = (state_q == ST_MUL1) ? ST_ADV : ST_OUT;
        end
      end
      ST_ADV: begin
        step_d  = step_use;
        phase_d = phase_q + step_use;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        mcand_d  = 32'(sine_mag);
        neg_d    = sine_val[26];
        mplier_d = MPLIER_W'(amp_q);
        acc_d    = '0;
        cnt_d    = '0;
        state_d  = ST_MUL2;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          dac_word_d  = DAC_CHAN_B_CMD | sample;
          if (held_q) begin
            amp_d = amp_attack;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      step_q      <= PHASE_RESET_STEP;
      amp_q       <= AMP_RESET;
      held_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      attack_q    <= ATTACK_RESET;
      decay_q     <= DECAY_RESET;
      full_q      <= FULL_RESET;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      amp_q       <= amp_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ATTACK: attack_q <= cfg_wdata_i;
          REG_DECAY:  decay_q  <= cfg_wdata_i;
          REG_FULL:   full_q   <= cfg_wdata_i;
          default: begin
            // drop writes to unknown indexes
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    acc_q      <= acc_d;
    lo_q       <= lo_d;
    neg_q      <= neg_d;
    dac_word_q <= dac_word_d;
  end

endmodule

`default_nettype wire
